// ----- src/quaternion_multiply_normalize_assert.svh -----
// Assertion helpers for the normalized quaternion product.
// Each use expects clk and arst_n in scope.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH

// Same-cycle implication
`define QMN_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("qmn: assertion failed");

// Next-cycle implication
`define QMN_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("qmn: assertion failed");

`endif

// ----- src/qmn_pkg.sv -----
`timescale 1ns / 1ps
package qmn_pkg;
	localparam int CW   = 16;   // component width, Q1.15
	localparam int PW   = 32;   // one Q2.30 product
	localparam int SUMW = 34;   // signed sum of four products
	localparam int MAGW = 33;   // magnitude of a sum
	localparam int HW   = 17;   // upper half of a magnitude
	localparam int LW   = 16;   // lower half of a magnitude
	localparam int SQW  = 65;   // square of a magnitude
	localparam int SSW  = 67;   // sum of four squares
	localparam int WW   = 104;  // root recurrence width
	localparam int KW   = 17;   // root quotient digits
	localparam int NDIG = 17;   // digit stages

	typedef struct packed {
		logic signed [CW-1:0] left_w;
		logic signed [CW-1:0] left_x;
		logic signed [CW-1:0] left_y;
		logic signed [CW-1:0] left_z;
		logic signed [CW-1:0] right_w;
		logic signed [CW-1:0] right_x;
		logic signed [CW-1:0] right_y;
		logic signed [CW-1:0] right_z;
	} req_t;

	typedef struct packed {
		logic signed [CW-1:0] prod_w;
		logic signed [CW-1:0] prod_x;
		logic signed [CW-1:0] prod_y;
		logic signed [CW-1:0] prod_z;
		logic                 zero_norm;
	} rsp_t;

	// State of the quotient recurrence for all four lanes
	typedef struct packed {
		logic [3:0][WW-1:0] r;   // remaining 2^32*c^2 - k^2*S
		logic [3:0][WW-1:0] p;   // k*S
		logic [3:0][KW-1:0] k;   // quotient so far
		logic [3:0]         neg; // component sign
		logic [SSW-1:0]     s;   // squared norm
	} root_t;
endpackage

// ----- src/qmn_product.sv -----
`timescale 1ns / 1ps
module qmn_product (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  qmn_pkg::req_t                 in_data,
	output logic                          valid_s2,
	output logic [3:0][qmn_pkg::SUMW-1:0] sum_s2
);
	import qmn_pkg::*;

	logic signed [PW-1:0] pr_s1 [16];
	logic signed [PW-1:0] pr    [16];
	logic                 valid_s1;

	// Form the sixteen partial products, grouped per result component
	always_comb begin
		pr[0]  = in_data.left_w * in_data.right_w;
		pr[1]  = in_data.left_x * in_data.right_x;
		pr[2]  = in_data.left_y * in_data.right_y;
		pr[3]  = in_data.left_z * in_data.right_z;
		pr[4]  = in_data.left_w * in_data.right_x;
		pr[5]  = in_data.left_x * in_data.right_w;
		pr[6]  = in_data.left_y * in_data.right_z;
		pr[7]  = in_data.left_z * in_data.right_y;
		pr[8]  = in_data.left_w * in_data.right_y;
		pr[9]  = in_data.left_x * in_data.right_z;
		pr[10] = in_data.left_y * in_data.right_w;
		pr[11] = in_data.left_z * in_data.right_x;
		pr[12] = in_data.left_w * in_data.right_z;
		pr[13] = in_data.left_x * in_data.right_y;
		pr[14] = in_data.left_y * in_data.right_x;
		pr[15] = in_data.left_z * in_data.right_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 16; i++) pr_s1[i] <= pr[i];
		end
	end

	// Sum with the Hamilton signs at full width
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2[0] <= SUMW'(pr_s1[0]) - SUMW'(pr_s1[1]) - SUMW'(pr_s1[2])
				- SUMW'(pr_s1[3]);
			sum_s2[1] <= SUMW'(pr_s1[4]) + SUMW'(pr_s1[5]) + SUMW'(pr_s1[6])
				- SUMW'(pr_s1[7]);
			sum_s2[2] <= SUMW'(pr_s1[8]) - SUMW'(pr_s1[9]) + SUMW'(pr_s1[10])
				+ SUMW'(pr_s1[11]);
			sum_s2[3] <= SUMW'(pr_s1[12]) + SUMW'(pr_s1[13]) - SUMW'(pr_s1[14])
				+ SUMW'(pr_s1[15]);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end
endmodule

// ----- src/qmn_square.sv -----
`timescale 1ns / 1ps
module qmn_square (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_s2,
	input  logic [3:0][qmn_pkg::SUMW-1:0] sum_s2,
	output logic                          valid_s5,
	output qmn_pkg::root_t                root_s5
);
	import qmn_pkg::*;

	logic [3:0][2*HW-1:0]    hh_s3;
	logic [3:0][HW+LW-1:0]   hl_s3;
	logic [3:0][2*LW-1:0]    ll_s3;
	logic [3:0]              neg_s3, neg_s4;
	logic [3:0][SQW-1:0]     sq_s4;
	logic                    valid_s3, valid_s4;
	logic [3:0][MAGW-1:0]    mag;
	logic [SUMW-1:0]         abs_v [4];

	// Take magnitudes and split each into halves
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			abs_v[i] = sum_s2[i][SUMW-1] ? (~sum_s2[i] + 1'b1) : sum_s2[i];
			mag[i]   = abs_v[i][MAGW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				hh_s3[i]  <= mag[i][MAGW-1:LW] * mag[i][MAGW-1:LW];
				hl_s3[i]  <= mag[i][MAGW-1:LW] * mag[i][LW-1:0];
				ll_s3[i]  <= mag[i][LW-1:0] * mag[i][LW-1:0];
				neg_s3[i] <= sum_s2[i][SUMW-1];
			end
		end
	end

	// Combine partial products into full squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s4[i] <= (SQW'(hh_s3[i]) << (2*LW)) + (SQW'(hl_s3[i]) << (LW+1))
					+ SQW'(ll_s3[i]);
			end
			neg_s4 <= neg_s3;
		end
	end

	// Sum squares and seed the root recurrence
	always_ff @(posedge clk) begin
		if (en) begin
			root_s5.s <= SSW'(sq_s4[0]) + SSW'(sq_s4[1]) + SSW'(sq_s4[2])
				+ SSW'(sq_s4[3]);
			for (int i = 0; i < 4; i++) begin
				root_s5.r[i] <= WW'(sq_s4[i]) << (2*CW);
				root_s5.p[i] <= '0;
				root_s5.k[i] <= '0;
			end
			root_s5.neg <= neg_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end
endmodule

// ----- src/qmn_root_step.sv -----
`timescale 1ns / 1ps
module qmn_root_step #(
	parameter int J = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  qmn_pkg::root_t in_root,
	output logic           out_valid,
	output qmn_pkg::root_t out_root
);
	import qmn_pkg::*;

	logic [WW-1:0] trial [4];
	logic [WW-1:0] s_w;
	root_t         nxt;

	// Try setting quotient bit J: (k+2^J)^2*S - k^2*S = 2^(J+1)*k*S + 2^(2J)*S
	always_comb begin
		s_w = WW'(in_root.s);
		nxt = in_root;
		for (int i = 0; i < 4; i++) begin
			trial[i] = (in_root.p[i] << (J+1)) + (s_w << (2*J));
			if (in_root.r[i] >= trial[i]) begin
				nxt.r[i]    = in_root.r[i] - trial[i];
				nxt.p[i]    = in_root.p[i] + (s_w << J);
				nxt.k[i][J] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_root <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end
endmodule

// ----- src/quaternion_multiply_normalize.sv -----
// Normalized Hamilton product of two Q1.15 quaternions, scalar first. Each
// output component is 2^15*c/|c| of the exact product, rounded to nearest
// (ties away from zero) and saturated to Q1.15; a zero product gives zeros
// with zero_norm set. One beat enters per clock unless held, and each passes
// two stages of products and sums, three stages of squaring and the norm
// sum, seventeen quotient digit stages (one bit each) and the output
// register. The whole pipeline holds while a result waits for rsp_ready.
`timescale 1ns / 1ps
module quaternion_multiply_normalize (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  qmn_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output qmn_pkg::rsp_t rsp_data
);
	import qmn_pkg::*;
	`include "quaternion_multiply_normalize_assert.svh"

	logic                  en;
	logic                  valid_s2, valid_s5;
	logic [3:0][SUMW-1:0]  sum_s2;
	root_t                 stg [NDIG+1];
	logic                  vld [NDIG+1];
	logic                  rsp_valid_q;
	rsp_t                  rsp_q, rsp_d;
	logic [KW:0]           m_w [4];
	logic [CW-1:0]         comp [4];
	logic                  zero;

	// Advance everything unless a result is held
	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	qmn_product u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req_valid),
		.in_data  (req_data),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2)
	);

	qmn_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2),
		.valid_s5 (valid_s5),
		.root_s5  (stg[0])
	);
	assign vld[0] = valid_s5;

	// Quotient digits, most significant first
	for (genvar g = 0; g < NDIG; g++) begin : g_dig
		qmn_root_step #(.J(KW-1-g)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[g]),
			.in_root   (stg[g]),
			.out_valid (vld[g+1]),
			.out_root  (stg[g+1])
		);
	end

	// Round, apply sign, saturate
	always_comb begin
		zero = (stg[NDIG].s == '0);
		for (int i = 0; i < 4; i++) begin
			m_w[i] = ((KW+1)'(stg[NDIG].k[i]) + 1'b1) >> 1;
			if (zero) begin
				comp[i] = '0;
			end else if (stg[NDIG].neg[i]) begin
				comp[i] = ~m_w[i][CW-1:0] + 1'b1;
			end else if (m_w[i] > (KW+1)'(2**(CW-1) - 1)) begin
				comp[i] = CW'(2**(CW-1) - 1);
			end else begin
				comp[i] = m_w[i][CW-1:0];
			end
		end
		rsp_d.prod_w    = comp[0];
		rsp_d.prod_x    = comp[1];
		rsp_d.prod_y    = comp[2];
		rsp_d.prod_z    = comp[3];
		rsp_d.zero_norm = zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= vld[NDIG];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`QMN_ASSERT_IMP(a_zero_out, rsp_valid && rsp_data.zero_norm, rsp_data.prod_w == 0 && rsp_data.prod_x == 0 && rsp_data.prod_y == 0 && rsp_data.prod_z == 0)
	`QMN_ASSERT_IMP(a_unit_nonzero, rsp_valid && !rsp_data.zero_norm, rsp_data.prod_w != 0 || rsp_data.prod_x != 0 || rsp_data.prod_y != 0 || rsp_data.prod_z != 0)
	`QMN_ASSERT_IMP(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)
	`QMN_ASSERT_NXT(a_last_hold, vld[NDIG] && !en, vld[NDIG])
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import qmn_pkg::*;

	localparam int LATENCY     = 23;
	localparam int CYCLE_LIMIT = 200000;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req_data;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp_data;

	rsp_t  expected_products[$];
	int    error_count;
	int    cycle_count;
	bit    calm;

	quaternion_multiply_normalize u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounded, saturated 2^15*c/sqrt(sq): largest m with (2^16|c|)^2 >= (2m-1)^2*sq
	function automatic logic signed [15:0] scaled_component(longint c, logic [66:0] sq);
		logic [127:0] mag_sq;
		logic [127:0] bound;
		longint       mag;
		longint       lo;
		longint       hi;
		longint       mid;
		mag = (c < 0) ? -c : c;
		mag_sq = (128'(mag) << 16) * (128'(mag) << 16);
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			bound = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(sq);
			if (mag_sq >= bound) lo = mid;
			else hi = mid - 1;
		end
		if (c < 0) return 16'(-lo);
		if (lo > 32767) lo = 32767;
		return 16'(lo);
	endfunction

	// Hamilton product, scalar first, then normalize
	function automatic rsp_t normalized_product(req_t q);
		longint      lw, lx, ly, lz, rw, rx, ry, rz;
		longint      c[4];
		logic [66:0] sq;
		rsp_t        r;
		lw = longint'(q.left_w);  lx = longint'(q.left_x);
		ly = longint'(q.left_y);  lz = longint'(q.left_z);
		rw = longint'(q.right_w); rx = longint'(q.right_x);
		ry = longint'(q.right_y); rz = longint'(q.right_z);
		c[0] = lw * rw - lx * rx - ly * ry - lz * rz;
		c[1] = lw * rx + lx * rw + ly * rz - lz * ry;
		c[2] = lw * ry - lx * rz + ly * rw + lz * rx;
		c[3] = lw * rz + lx * ry - ly * rx + lz * rw;
		sq = '0;
		// A square can pass 2^63, so take it as unsigned
		for (int i = 0; i < 4; i++) sq += 67'($unsigned(c[i] * c[i]));
		r = '0;
		if (sq == 0) begin
			r.zero_norm = 1'b1;
			return r;
		end
		r.prod_w = scaled_component(c[0], sq);
		r.prod_x = scaled_component(c[1], sq);
		r.prod_y = scaled_component(c[2], sq);
		r.prod_z = scaled_component(c[3], sq);
		return r;
	endfunction

	// Send one beat, with random idle cycles ahead of it
	task automatic send_quaternions(req_t q);
		while (!calm && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_products.push_back(normalized_product(q));
		@(negedge clk);
	endtask

	function automatic req_t pack_pair(logic [15:0] a, b, c, d, e, f, g, h);
		req_t q;
		q = {a, b, c, d, e, f, g, h};
		return q;
	endfunction

	function automatic logic [15:0] random_component();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Drop valid and wait until every expected result has come
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_products.size() != 0);
	endtask

	// Drive rsp_ready with random stalls
	always @(negedge clk) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else rsp_ready <= calm || ($urandom_range(99) >= 18);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_products.size() == 0) begin
				$error("unexpected result %h", rsp_data);
				error_count++;
			end else begin
				exp_r = expected_products.pop_front();
				if (rsp_data.prod_w !== exp_r.prod_w) begin
					$error("prod_w exp %0d got %0d", exp_r.prod_w, rsp_data.prod_w);
					error_count++;
				end
				if (rsp_data.prod_x !== exp_r.prod_x) begin
					$error("prod_x exp %0d got %0d", exp_r.prod_x, rsp_data.prod_x);
					error_count++;
				end
				if (rsp_data.prod_y !== exp_r.prod_y) begin
					$error("prod_y exp %0d got %0d", exp_r.prod_y, rsp_data.prod_y);
					error_count++;
				end
				if (rsp_data.prod_z !== exp_r.prod_z) begin
					$error("prod_z exp %0d got %0d", exp_r.prod_z, rsp_data.prod_z);
					error_count++;
				end
				if (rsp_data.zero_norm !== exp_r.zero_norm) begin
					$error("zero_norm exp %0d got %0d", exp_r.zero_norm,
						rsp_data.zero_norm);
					error_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Extremes, zero products, identities and saturation
	task automatic test_directed();
		send_quaternions(pack_pair('0, '0, '0, '0, '0, '0, '0, '0));
		send_quaternions(pack_pair(16'h7fff, '0, '0, '0, '0, '0, '0, '0));
		send_quaternions(pack_pair(16'h7fff, '0, '0, '0, 16'h7fff, '0, '0, '0));
		send_quaternions(pack_pair(16'h8000, '0, '0, '0, 16'h8000, '0, '0, '0));
		send_quaternions(pack_pair(16'h8000, '0, '0, '0, 16'h7fff, '0, '0, '0));
		send_quaternions(pack_pair('0, 16'h7fff, '0, '0, '0, 16'h7fff, '0, '0));
		send_quaternions(pack_pair('0, '0, 16'h8000, '0, '0, '0, 16'h7fff, '0));
		send_quaternions(pack_pair('0, '0, '0, 16'h8000, '0, '0, '0, 16'h8000));
		send_quaternions(pack_pair('0, 16'h7fff, '0, '0, '0, '0, 16'h7fff, '0));
		send_quaternions(pack_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_quaternions(pack_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_quaternions(pack_pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
		send_quaternions(pack_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
		send_quaternions(pack_pair(16'd1, '0, '0, '0, 16'd1, '0, '0, '0));
		send_quaternions(pack_pair(16'd1, 16'd1, 16'd1, 16'd1,
			16'd1, 16'hffff, 16'hffff, 16'hffff));
		send_quaternions(pack_pair(16'd1, 16'd1, '0, '0, 16'd1, 16'd1, '0, '0));
		send_quaternions(pack_pair(16'd3, 16'd4, '0, '0, 16'd1, '0, '0, '0));
		send_quaternions(pack_pair(16'hffff, '0, '0, '0, '0, '0, '0, 16'hffff));
		send_quaternions(pack_pair('0, '0, '0, '0, 16'h1234, 16'h8000, 16'h7fff, 16'd5));
	endtask

	// Random pairs, plenty of extremes and tiny values
	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_quaternions(pack_pair(random_component(), random_component(),
				random_component(), random_component(), random_component(),
				random_component(), random_component(), random_component()));
	endtask

	// Back-to-back beats with no stalls on either side
	task automatic test_full_rate(int count);
		calm = 1'b1;
		test_random(count);
		drain_results();
		calm = 1'b0;
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		calm        = 1'b0;
		req_valid   = 1'b0;
		req_data    = '0;
		rsp_ready   = 1'b0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		drain_results();
		test_random(200);
		test_full_rate(100);
		test_random(100);
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);

		if (error_count == 0 && expected_products.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
